/* sv/pie_pkg.sv */
// ============================================================================
// pie_pkg
// Shared types and constants for the postfix integer evaluator.
// ============================================================================
package pie_pkg;

    // Operand width and stack depth
    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 16;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    // Character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result status codes
    localparam logic [2:0] STATUS_OK    = 3'd0;
    localparam logic [2:0] STATUS_FEW   = 3'd1;
    localparam logic [2:0] STATUS_COUNT = 3'd2;
    localparam logic [2:0] STATUS_OVER  = 3'd3;
    localparam logic [2:0] STATUS_DIV0  = 3'd4;

    // Per-cell stack command
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_SHIFT_OUT
    } cell_cmd_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* sv/pie_char_if.sv */
// ============================================================================
// pie_char_if
// Character channel: one ASCII character per item.
// ============================================================================
interface pie_char_if;

    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);

endinterface

/* sv/pie_result_if.sv */
// ============================================================================
// pie_result_if
// Result channel: final value and status of one expression per item.
// ============================================================================
interface pie_result_if;

    logic                              valid;
    logic                              ready;
    logic signed [pie_pkg::DATA_W-1:0] value;
    logic [2:0]                        status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);

endinterface

/* sv/postfix_integer_evaluator.sv */
// ============================================================================
// postfix_integer_evaluator
// RPN integer evaluator: one character per item, 32-bit operand stack held
// in a row of shifting cells, one result per newline or error.
// ============================================================================
//
//   channel   dir   payload                      handshake
//   chars     in    ch[7:0]                      valid/ready
//   results   out   value[31:0] s, status[2:0]   valid/ready
//
// One item is in flight at a time. A character passes S_IDLE and S_EXEC;
// S_EXEC repeats if a pending number is pushed first; '*' adds S_MUL for
// the product register; '/' waits in S_DIV for the 32-step bit-serial divider.
// rst_n clears the counters and flags; stack cells need no reset.
// A result waiting on results.ready stalls only a character that must
// emit; others proceed.
// ============================================================================
module postfix_integer_evaluator (
    input  logic                clk,
    input  logic                rst_n,
    pie_char_if.sink            chars,
    pie_result_if.source        results
);

    localparam int W  = pie_pkg::DATA_W;
    localparam int D  = pie_pkg::STACK_DEPTH;
    localparam int CW = pie_pkg::COUNT_W;

    pie_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic          in_number_reg, in_number_next;
    logic          skip_reg, skip_next;
    logic [7:0]    ch_reg;
    logic [W-1:0]  prod_reg;

    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  value_reg;
    logic [2:0]    status_reg;

    // Stack chain
    pie_pkg::cell_cmd_t cmd_top;
    pie_pkg::cell_cmd_t cmd_rest;
    logic [W-1:0]       top_in;
    logic [W-1:0]       cell_q [D];
    logic [W-1:0]       top_q;
    logic [W-1:0]       sec_q;

    // Divider
    pie_pkg::div_req_t div_req;
    pie_pkg::div_rsp_t div_rsp;

    // Control outputs
    logic          emit;
    logic [W-1:0]  emit_value;
    logic [2:0]    emit_status;
    logic          mul_load;

    // Decode of the held character
    logic is_digit, is_nl, is_op, stack_full, few;
    logic go_push, act_nl, act_op, wants_emit, stall;

    assign top_q = cell_q[0];
    assign sec_q = cell_q[1];

    assign is_digit   = ch_reg inside {[pie_pkg::CH_ZERO:pie_pkg::CH_NINE]};
    assign is_nl      = (ch_reg == pie_pkg::CH_NL);
    assign is_op      = ch_reg inside {pie_pkg::CH_PLUS, pie_pkg::CH_MINUS,
                                       pie_pkg::CH_STAR, pie_pkg::CH_SLASH};
    assign stack_full = (count_reg == CW'(D));
    assign few        = (count_reg < CW'(2));

    assign go_push = !skip_reg && !is_digit && in_number_reg;
    assign act_nl  = !skip_reg && !in_number_reg && is_nl;
    assign act_op  = !skip_reg && !in_number_reg && is_op;

    assign wants_emit = (go_push && stack_full) || act_nl || (act_op && few)
                      || (act_op && !few && (ch_reg == pie_pkg::CH_SLASH)
                          && (top_q == '0));
    assign stall = (state_reg == pie_pkg::S_EXEC) && wants_emit
                 && out_valid_reg && !results.ready;

    // Cell row: top of stack is cell 0
    for (genvar i = 0; i < D; i++)
    begin : g_cell
        logic [W-1:0] prev_d;
        logic [W-1:0] next_d;
        if (i == 0)
        begin : g_first
            assign prev_d = top_in;
        end
        else
        begin : g_mid
            assign prev_d = cell_q[i-1];
        end
        if (i == D - 1)
        begin : g_last
            assign next_d = cell_q[i];
        end
        else
        begin : g_inner
            assign next_d = cell_q[i+1];
        end
        pie_cell u_cell (
            .clk       (clk),
            .cmd       ((i == 0) ? cmd_top : cmd_rest),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_q[i])
        );
    end

    pie_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pie_pkg::S_IDLE:
            begin
                if (chars.valid)
                begin
                    state_next = pie_pkg::S_EXEC;
                end
            end
            pie_pkg::S_EXEC:
            begin
                if (stall)
                begin
                    state_next = pie_pkg::S_EXEC;
                end
                else if (go_push && !stack_full)
                begin
                    state_next = pie_pkg::S_EXEC;
                end
                else if (act_op && !few && (ch_reg == pie_pkg::CH_STAR))
                begin
                    state_next = pie_pkg::S_MUL;
                end
                else if (act_op && !few && (ch_reg == pie_pkg::CH_SLASH)
                         && (top_q != '0))
                begin
                    state_next = pie_pkg::S_DIV;
                end
                else
                begin
                    state_next = pie_pkg::S_IDLE;
                end
            end
            pie_pkg::S_MUL:
            begin
                state_next = pie_pkg::S_IDLE;
            end
            pie_pkg::S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = pie_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pie_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath control
    always_comb
    begin
        cmd_top          = pie_pkg::CELL_HOLD;
        cmd_rest         = pie_pkg::CELL_HOLD;
        top_in           = acc_reg;
        count_next       = count_reg;
        acc_next         = acc_reg;
        in_number_next   = in_number_reg;
        skip_next        = skip_reg;
        emit             = 1'b0;
        emit_value       = '0;
        emit_status      = pie_pkg::STATUS_OK;
        mul_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sec_q;
        div_req.divisor  = top_q;
        case (state_reg)
            pie_pkg::S_EXEC:
            begin
                if (stall)
                begin
                    // wait for the result slot
                end
                else if (skip_reg)
                begin
                    if (is_nl)
                    begin
                        count_next     = '0;
                        acc_next       = '0;
                        in_number_next = 1'b0;
                        skip_next      = 1'b0;
                    end
                end
                else if (is_digit)
                begin
                    if (in_number_reg)
                    begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1)
                                 + {{(W-4){1'b0}}, ch_reg[3:0]};
                    end
                    else
                    begin
                        acc_next = {{(W-4){1'b0}}, ch_reg[3:0]};
                    end
                    in_number_next = 1'b1;
                end
                else if (in_number_reg)
                begin
                    // finish the pending number; once pushed, the character runs again next
                    in_number_next = 1'b0;
                    acc_next       = '0;
                    if (stack_full)
                    begin
                        emit        = 1'b1;
                        emit_status = pie_pkg::STATUS_OVER;
                        if (is_nl)
                        begin
                            count_next = '0;
                        end
                        else
                        begin
                            skip_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd_top    = pie_pkg::CELL_SHIFT_IN;
                        cmd_rest   = pie_pkg::CELL_SHIFT_IN;
                        top_in     = acc_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (is_nl)
                begin
                    emit = 1'b1;
                    if (count_reg == CW'(1))
                    begin
                        emit_value  = top_q;
                        emit_status = pie_pkg::STATUS_OK;
                    end
                    else
                    begin
                        emit_status = pie_pkg::STATUS_COUNT;
                    end
                    count_next = '0;
                    acc_next   = '0;
                    skip_next  = 1'b0;
                end
                else if (is_op)
                begin
                    if (few)
                    begin
                        emit        = 1'b1;
                        emit_status = pie_pkg::STATUS_FEW;
                        skip_next   = 1'b1;
                    end
                    else
                    begin
                        case (ch_reg)
                            pie_pkg::CH_PLUS:
                            begin
                                cmd_top    = pie_pkg::CELL_SHIFT_IN;
                                cmd_rest   = pie_pkg::CELL_SHIFT_OUT;
                                top_in     = sec_q + top_q;
                                count_next = count_reg - 1'b1;
                            end
                            pie_pkg::CH_MINUS:
                            begin
                                cmd_top    = pie_pkg::CELL_SHIFT_IN;
                                cmd_rest   = pie_pkg::CELL_SHIFT_OUT;
                                top_in     = sec_q - top_q;
                                count_next = count_reg - 1'b1;
                            end
                            pie_pkg::CH_STAR:
                            begin
                                mul_load = 1'b1;
                            end
                            pie_pkg::CH_SLASH:
                            begin
                                if (top_q == '0)
                                begin
                                    emit        = 1'b1;
                                    emit_status = pie_pkg::STATUS_DIV0;
                                    skip_next   = 1'b1;
                                end
                                else
                                begin
                                    div_req.start = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            pie_pkg::S_MUL:
            begin
                cmd_top    = pie_pkg::CELL_SHIFT_IN;
                cmd_rest   = pie_pkg::CELL_SHIFT_OUT;
                top_in     = prod_reg;
                count_next = count_reg - 1'b1;
            end
            pie_pkg::S_DIV:
            begin
                if (div_rsp.done)
                begin
                    cmd_top    = pie_pkg::CELL_SHIFT_IN;
                    cmd_rest   = pie_pkg::CELL_SHIFT_OUT;
                    top_in     = div_rsp.quotient;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result slot
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pie_pkg::S_IDLE;
            count_reg     <= '0;
            acc_reg       <= '0;
            in_number_reg <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            in_number_reg <= in_number_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            ch_reg <= chars.ch;
        end
        if (mul_load)
        begin
            prod_reg <= sec_q * top_q;
        end
        if (emit)
        begin
            value_reg  <= emit_value;
            status_reg <= emit_status;
        end
    end

    assign chars.ready    = (state_reg == pie_pkg::S_IDLE);
    assign results.valid  = out_valid_reg;
    assign results.value  = value_reg;
    assign results.status = status_reg;

endmodule

/* sv/pie_cell.sv */
// ============================================================================
// pie_cell
// One operand stack entry; shifts toward or away from the top of stack.
// ============================================================================
module pie_cell (
    input  logic                          clk,
    input  pie_pkg::cell_cmd_t            cmd,
    input  logic [pie_pkg::DATA_W-1:0]    prev_data,
    input  logic [pie_pkg::DATA_W-1:0]    next_data,
    output logic [pie_pkg::DATA_W-1:0]    data
);

    logic [pie_pkg::DATA_W-1:0] data_reg;
    logic [pie_pkg::DATA_W-1:0] data_next;

    // Push takes the entry above, pop takes the entry below
    always_comb
    begin
        case (cmd)
            pie_pkg::CELL_SHIFT_IN:  data_next = prev_data;
            pie_pkg::CELL_SHIFT_OUT: data_next = next_data;
            default:                 data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* sv/pie_div.sv */
// ============================================================================
// pie_div
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// ============================================================================
module pie_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pie_pkg::div_req_t req,
    output pie_pkg::div_rsp_t rsp
);

    localparam int W = pie_pkg::DATA_W;

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [pie_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                    rem_reg, rem_next;
    logic [W-1:0]                    quo_reg, quo_next;
    logic [W-1:0]                    den_reg, den_next;
    logic                            neg_reg, neg_next;

    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] abs_s;
    logic [W-1:0] abs_t;

    // Operand magnitudes; the most negative value maps to 2^31 unsigned
    assign abs_s = req.dividend[W-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign abs_t = req.divisor[W-1]  ? (~req.divisor + 1'b1)  : req.divisor;

    // Restoring step
    assign rem_sh = {rem_reg, quo_reg[W-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = ~diff[W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = abs_s;
            den_next  = abs_t;
            neg_next  = req.dividend[W-1] ^ req.divisor[W-1];
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[W-1:0] : rem_sh[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pie_pkg::DIV_CNT_W'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Sign fix-up on the way out
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

/* sv/pie_checker.sv */
// ============================================================================
// pie_checker
// Port-level checks for the postfix integer evaluator, bound to the top.
// ============================================================================
module pie_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       chars_valid,
    input logic                       chars_ready,
    input logic                       results_valid,
    input logic                       results_ready,
    input logic [pie_pkg::DATA_W-1:0] results_value,
    input logic [2:0]                 results_status
);

    // Stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=>
            results_valid && $stable(results_value) && $stable(results_status))
        else $error("result changed while stalled");

    // One character in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        chars_valid && chars_ready |=> !chars_ready)
        else $error("input taken while an item is in flight");

    // Error results carry zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && (results_status != pie_pkg::STATUS_OK) |->
            (results_value == '0))
        else $error("error result with nonzero value");

    // Status is a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid |->
            (results_status == pie_pkg::STATUS_OK)
            || (results_status == pie_pkg::STATUS_FEW)
            || (results_status == pie_pkg::STATUS_COUNT)
            || (results_status == pie_pkg::STATUS_OVER)
            || (results_status == pie_pkg::STATUS_DIV0))
        else $error("undefined status code");

endmodule

bind postfix_integer_evaluator pie_checker u_pie_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .chars_valid    (chars.valid),
    .chars_ready    (chars.ready),
    .results_valid  (results.valid),
    .results_ready  (results.ready),
    .results_value  (results.value),
    .results_status (results.status)
);

/* tb/tb_postfix_integer_evaluator.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_postfix_integer_evaluator
// Self-checking testbench for the postfix integer evaluator. A clocked driver
// feeds characters from a queue, and an in-bench copy of the evaluator
// predicts each result. A clocked monitor checks every result item in order
// against the predicted results. Phases vary the idling on both channels.
// ============================================================================
module tb_postfix_integer_evaluator;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no item moving
    localparam int LONG_STALL   = 400;   // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 60;    // covers the slowest divide
    localparam int PHASE_ITEMS  = 290;

    localparam logic [7:0] OPS [4] = '{pie_pkg::CH_PLUS, pie_pkg::CH_MINUS,
                                       pie_pkg::CH_STAR, pie_pkg::CH_SLASH};
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic signed [pie_pkg::DATA_W-1:0] value;
        logic [2:0]                        status;
    } result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Testbench-side drive of the block inputs
    logic       send_valid  = 1'b0;
    logic [7:0] send_ch     = 8'h00;
    logic       recv_ready  = 1'b0;
    logic       long_stall_req = 1'b0;
    int         stall_left  = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         quiet_cycles = 0;
    int         mismatches  = 0;

    logic [7:0] char_q[$];
    result_t    expect_q[$];

    // Predictor state
    logic [pie_pkg::DATA_W-1:0]  opnd_stk [pie_pkg::STACK_DEPTH];
    logic [pie_pkg::COUNT_W-1:0] opnd_cnt   = '0;
    logic [pie_pkg::DATA_W-1:0]  num_acc    = '0;
    logic                        num_active = 1'b0;
    logic                        skipping   = 1'b0;

    pie_char_if   chars_if ();
    pie_result_if res_if ();

    assign chars_if.valid = send_valid;
    assign chars_if.ch    = send_ch;
    assign res_if.ready   = recv_ready;

    postfix_integer_evaluator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (res_if)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void end_expr();
        opnd_cnt   = '0;
        num_acc    = '0;
        num_active = 1'b0;
        skipping   = 1'b0;
    endfunction

    function automatic bit is_active_char(logic [7:0] c);
        return (c >= pie_pkg::CH_ZERO && c <= pie_pkg::CH_NINE) ||
               c == pie_pkg::CH_NL || c == pie_pkg::CH_PLUS ||
               c == pie_pkg::CH_MINUS || c == pie_pkg::CH_STAR ||
               c == pie_pkg::CH_SLASH;
    endfunction

    function automatic void eval_char(input logic [7:0] c, output bit emit,
                                      output result_t r);
        logic [pie_pkg::DATA_W-1:0] top;
        logic [pie_pkg::DATA_W-1:0] sec;
        logic [pie_pkg::DATA_W-1:0] res;
        longint                     quo;
        bit                         is_nl;
        bit                         is_op;
        emit  = 1'b0;
        r     = '0;
        is_nl = (c == pie_pkg::CH_NL);
        is_op = (c == pie_pkg::CH_PLUS || c == pie_pkg::CH_MINUS ||
                 c == pie_pkg::CH_STAR || c == pie_pkg::CH_SLASH);

        // Error recovery: everything up to the newline is dropped
        if (skipping)
        begin
            if (is_nl)
                end_expr();
            return;
        end

        if (c >= pie_pkg::CH_ZERO && c <= pie_pkg::CH_NINE)
        begin
            if (num_active)
                num_acc = num_acc * 10 + pie_pkg::DATA_W'(c - pie_pkg::CH_ZERO);
            else
                num_acc = pie_pkg::DATA_W'(c - pie_pkg::CH_ZERO);
            num_active = 1'b1;
            return;
        end

        // A non-digit ends a pending number
        if (num_active)
        begin
            num_active = 1'b0;
            if (opnd_cnt >= pie_pkg::STACK_DEPTH)
            begin
                num_acc  = '0;
                if (is_nl)
                    end_expr();
                else
                    skipping = 1'b1;
                emit     = 1'b1;
                r.status = pie_pkg::STATUS_OVER;
                return;
            end
            opnd_stk[opnd_cnt] = num_acc;
            opnd_cnt           = opnd_cnt + 1'b1;
            num_acc            = '0;
        end

        if (is_nl)
        begin
            emit = 1'b1;
            if (opnd_cnt == 1)
            begin
                r.value  = opnd_stk[0];
                r.status = pie_pkg::STATUS_OK;
            end
            else
                r.status = pie_pkg::STATUS_COUNT;
            end_expr();
            return;
        end

        if (is_op)
        begin
            if (opnd_cnt < 2)
            begin
                skipping = 1'b1;
                emit     = 1'b1;
                r.status = pie_pkg::STATUS_FEW;
                return;
            end
            top      = opnd_stk[opnd_cnt - 1];
            sec      = opnd_stk[opnd_cnt - 2];
            opnd_cnt = opnd_cnt - 2'd2;
            case (c)
                pie_pkg::CH_PLUS:  res = sec + top;
                pie_pkg::CH_MINUS: res = sec - top;
                pie_pkg::CH_STAR:  res = sec * top;
                default:
                begin
                    if (top == '0)
                    begin
                        skipping = 1'b1;
                        emit     = 1'b1;
                        r.status = pie_pkg::STATUS_DIV0;
                        return;
                    end
                    // 64-bit quotient: min / -1 wraps back to min
                    quo = longint'($signed(sec)) / longint'($signed(top));
                    res = quo[pie_pkg::DATA_W-1:0];
                end
            endcase
            opnd_stk[opnd_cnt] = res;
            opnd_cnt           = opnd_cnt + 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            char_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] ignored_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (is_active_char(b));
        return b;
    endfunction

    task automatic push_number(logic [pie_pkg::DATA_W-1:0] v);
        logic [7:0] digits[$];
        if ($urandom_range(7) == 0)
            char_q.push_back(pie_pkg::CH_ZERO);
        if (v == 0)
            digits.push_back(pie_pkg::CH_ZERO);
        while (v != 0)
        begin
            digits.push_front(pie_pkg::CH_ZERO + 8'(v % 10));
            v = v / 10;
        end
        foreach (digits[i])
            char_q.push_back(digits[i]);
    endtask

    function automatic logic [pie_pkg::DATA_W-1:0] rand_operand();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return pie_pkg::DATA_W'($urandom_range(20));
            5, 6:          return pie_pkg::DATA_W'($urandom_range(999));
            7:             return pie_pkg::DATA_W'($urandom);
            default:
            begin
                case ($urandom_range(2))
                    0:       return 32'h8000_0000;
                    1:       return 32'hFFFF_FFFF;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
        endcase
    endfunction

    task automatic push_separator();
        if ($urandom_range(4) == 0)
            char_q.push_back(ignored_char());
        else
            char_q.push_back(CH_SPACE);
    endtask

    // Mostly well-formed expression with random content; deep ones may overflow
    task automatic push_expr();
        int  left;
        int  depth;
        bit  deep;
        deep  = ($urandom_range(9) == 0);
        left  = deep ? $urandom_range(14, 18) : $urandom_range(1, 6);
        depth = 0;
        while (left > 0 || depth > 1)
        begin
            if (left > 0 && (depth < 2 || deep || $urandom_range(1) == 0))
            begin
                if ($urandom_range(15) == 0)
                    for (int i = $urandom_range(11, 20); i > 0; i--)
                        char_q.push_back(pie_pkg::CH_ZERO + 8'($urandom_range(9)));
                else
                    push_number(rand_operand());
                left--;
                depth++;
                if (left > 0 || $urandom_range(1) == 0)
                    push_separator();
            end
            else
            begin
                char_q.push_back(OPS[$urandom_range(3)]);
                depth--;
                if ($urandom_range(5) == 0)
                    push_separator();
            end
        end
        if ($urandom_range(9) == 0)
            char_q.push_back(OPS[$urandom_range(3)]);
        char_q.push_back(pie_pkg::CH_NL);
    endtask

    // Broken sequence or plain noise
    task automatic push_junk();
        int len;
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(5))
                0, 1:    char_q.push_back(pie_pkg::CH_ZERO + 8'($urandom_range(9)));
                2:       char_q.push_back(OPS[$urandom_range(3)]);
                3:       char_q.push_back(CH_SPACE);
                4:       char_q.push_back(8'($urandom_range(255)));
                default: char_q.push_back(ignored_char());
            endcase
        end
        char_q.push_back(pie_pkg::CH_NL);
    endtask

    task automatic push_specials();
        // Most negative value divided by -1
        push_text("2147483648 0 1-/\n");
        // Overflow on a push ended by a space, then skipped operator
        for (int i = 0; i < pie_pkg::STACK_DEPTH + 1; i++)
            push_text("5 ");
        push_text("+\n");
        // Overflow on a push ended by the newline
        for (int i = 0; i < pie_pkg::STACK_DEPTH; i++)
            push_text("3 ");
        push_text("4\n");
        // Digit run long enough to wrap
        push_text("99999999999999999999\n");
    endtask

    task automatic wait_drained();
        while (char_q.size() != 0 || send_valid || expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Character driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        bit      emit;
        result_t r;
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_ch    <= 8'h00;
        end
        else
        begin
            if (send_valid && chars_if.ready)
            begin
                eval_char(send_ch, emit, r);
                if (emit)
                    expect_q.push_back(r);
            end
            if (!send_valid || chars_if.ready)
            begin
                if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    send_valid <= 1'b1;
                    send_ch    <= char_q.pop_front();
                end
                else
                    send_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result ready, with random stalls and one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (long_stall_req)
        begin
            recv_ready <= 1'b0;
            stall_left <= LONG_STALL;
        end
        else if (stall_left != 0)
        begin
            recv_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            recv_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expect_q.size() == 0)
            begin
                $error("unexpected result item: value %0d status %0d",
                       res_if.value, res_if.status);
                mismatches++;
            end
            else
            begin
                want = expect_q.pop_front();
                if (res_if.value !== want.value)
                begin
                    $error("value mismatch: expected %0d, got %0d",
                           want.value, res_if.value);
                    mismatches++;
                end
                if (res_if.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, res_if.status);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog on cycles with no item moving
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("postfix_integer_evaluator test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int start_len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, empty line, too few operands with
        // skipped digits, divide by zero, all of + - *, pending push at
        // newline with wrong count
        char_q.push_back(8'h00);
        char_q.push_back(8'hFF);
        push_text("\n");
        push_text("+9\n");
        push_text("7 0/\n");
        push_text("9 4-3*2+\n");
        push_text("3 4\n");
        wait_drained();

        // Random phases: none, sender idle, receiver stalls, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
            if (phase == 0)
            begin
                push_specials();
                long_stall_req <= 1'b1;
                @(posedge clk);
                long_stall_req <= 1'b0;
            end
            start_len = 0;
            while (start_len < PHASE_ITEMS)
            begin
                int prev_len;
                prev_len = char_q.size();
                if ($urandom_range(99) < 80)
                    push_expr();
                else
                    push_junk();
                start_len += char_q.size() - prev_len;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("postfix_integer_evaluator test passed");
        else
            $display("postfix_integer_evaluator test failed");
        $finish;
    end

endmodule
